>>> hdl/spr_pkg.sv
package spr_pkg;

    localparam int RAMP_STEPS   = 20;
    localparam int TICKS_PER_MS = 1000;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int PULSE_W   = 15;
    localparam int CUR_W     = 16;
    localparam int TIME_W    = 16;
    localparam int PERIOD_W  = 16;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd20000;
    localparam logic [CUR_W-1:0]    PULSE_RESET  = 16'd1500;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_MOVE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_US        = 1'b0,
        CFG_INITIAL_PULSE_US = 1'b1
    } spr_cfg_idx_t;

    localparam int IDX_W   = $clog2(RAMP_STEPS + 1);
    localparam int US_W    = $clog2(TICKS_PER_MS + 1);
    localparam int DLY_W   = $clog2((2**TIME_W - 1) / RAMP_STEPS + 1);
    localparam int INC_W   = $clog2((2**PULSE_W - 1) / RAMP_STEPS + 1) + 1;
    localparam int POS_W   = PULSE_W + 2;

    localparam int DIV_SHIFT = TIME_W + 5;
    localparam int DIV_RECIP = (2**DIV_SHIFT + RAMP_STEPS - 1) / RAMP_STEPS;
    localparam int RECIP_W   = $clog2(DIV_RECIP + 1);
    localparam int DIV_PROD_W = TIME_W + RECIP_W;

    typedef struct packed {
        logic [PULSE_W-1:0] origin_us;
        logic [PULSE_W-1:0] target_us;
        logic [TIME_W-1:0]  move_time_ms;
    } spr_move_t;

    typedef struct packed {
        logic [CUR_W-1:0] pulse_next;
        logic             moving_next;
    } spr_ramp_status_t;

endpackage

>>> hdl/spr_in_if.sv
interface spr_in_if;
    import spr_pkg::*;

    logic               valid;
    logic               ready;
    logic               command;
    logic [PULSE_W-1:0] origin_us;
    logic [PULSE_W-1:0] target_us;
    logic [TIME_W-1:0]  move_time_ms;

    modport source (
        output valid, command, origin_us, target_us, move_time_ms,
        input  ready
    );

    modport sink (
        input  valid, command, origin_us, target_us, move_time_ms,
        output ready
    );
endinterface

>>> hdl/spr_out_if.sv
interface spr_out_if;
    import spr_pkg::*;

    logic               valid;
    logic               ready;
    logic               pin_level;
    logic [PULSE_W-1:0] pulse_width;
    logic               moving;

    modport source (
        output valid, pin_level, pulse_width, moving,
        input  ready
    );

    modport sink (
        input  valid, pin_level, pulse_width, moving,
        output ready
    );
endinterface

>>> hdl/spr_pwm.sv
module spr_pwm (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         tick,
    input  logic [spr_pkg::PERIOD_W-1:0] period,
    input  logic [spr_pkg::CUR_W-1:0]    cur_pulse,
    output logic                         pin_next
);
    import spr_pkg::*;

    logic [PERIOD_W-1:0] count_reg, count_next;
    logic [CUR_W-1:0]    latched_reg, latched_next;
    logic                pin_reg;
    logic [PERIOD_W-1:0] per;
    logic [PERIOD_W-1:0] count_start;
    logic [PERIOD_W:0]   count_inc;

    always_comb
    begin
        per          = (period == '0) ? PERIOD_W'(1) : period;
        count_start  = (count_reg >= per) ? '0 : count_reg;
        latched_next = latched_reg;
        count_next   = count_reg;
        pin_next     = pin_reg;
        count_inc    = {1'b0, count_start} + (PERIOD_W+1)'(1);
        if (tick)
        begin
            if (count_start == '0)
            begin
                latched_next = cur_pulse;
            end
            pin_next   = count_start < latched_next;
            count_next = (count_inc >= {1'b0, per}) ? '0 : count_inc[PERIOD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            latched_reg <= PULSE_RESET;
            pin_reg     <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            latched_reg <= latched_next;
            pin_reg     <= pin_next;
        end
    end
endmodule

>>> hdl/spr_ramp.sv
module spr_ramp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      tick,
    input  logic                      start,
    input  spr_pkg::spr_move_t        move,
    output logic [spr_pkg::CUR_W-1:0] cur_pulse,
    output spr_pkg::spr_ramp_status_t status
);
    import spr_pkg::*;

    logic [CUR_W-1:0]        cur_reg, cur_next;
    logic [PULSE_W-1:0]      origin_reg, origin_next;
    logic [PULSE_W-1:0]      target_reg, target_next;
    logic signed [INC_W-1:0] inc_reg, inc_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [DLY_W-1:0]        delay_reg, delay_next;
    logic [DLY_W-1:0]        ms_reg, ms_next;
    logic [US_W-1:0]         us_reg, us_next;
    logic                    active_reg, active_next;

    logic signed [PULSE_W+1:0]       delta;
    logic [PULSE_W:0]                delta_abs;
    logic [DIV_PROD_W-1:0]           delta_prod;
    logic [DIV_PROD_W-1:0]           time_prod;
    logic [INC_W-1:0]                inc_mag;
    logic [US_W:0]                   us_inc;
    logic [DLY_W:0]                  ms_inc;
    logic [IDX_W:0]                  idx_inc;
    logic signed [INC_W+IDX_W:0]     step_prod;
    logic signed [POS_W-1:0]         pos;

    always_comb
    begin
        delta      = $signed({2'b00, move.target_us}) - $signed({2'b00, move.origin_us});
        delta_abs  = delta[PULSE_W+1] ? (PULSE_W+1)'(-delta) : delta[PULSE_W:0];
        delta_prod = DIV_PROD_W'(delta_abs) * DIV_PROD_W'(DIV_RECIP);
        time_prod  = DIV_PROD_W'(move.move_time_ms) * DIV_PROD_W'(DIV_RECIP);
        inc_mag    = INC_W'(delta_prod >> DIV_SHIFT);

        us_inc    = {1'b0, us_reg} + (US_W+1)'(1);
        ms_inc    = {1'b0, ms_reg} + (DLY_W+1)'(1);
        idx_inc   = {1'b0, idx_reg} + (IDX_W+1)'(1);
        step_prod = inc_reg * $signed({1'b0, idx_inc});
        pos       = $signed({2'b00, origin_reg}) + POS_W'(step_prod);

        cur_next    = cur_reg;
        origin_next = origin_reg;
        target_next = target_reg;
        inc_next    = inc_reg;
        idx_next    = idx_reg;
        delay_next  = delay_reg;
        ms_next     = ms_reg;
        us_next     = us_reg;
        active_next = active_reg;

        if (start)
        begin
            origin_next = move.origin_us;
            target_next = move.target_us;
            inc_next    = delta[PULSE_W+1] ? -$signed(inc_mag) : $signed(inc_mag);
            delay_next  = DLY_W'(time_prod >> DIV_SHIFT);
            idx_next    = '0;
            ms_next     = '0;
            us_next     = '0;
            if (move.move_time_ms < TIME_W'(RAMP_STEPS))
            begin
                cur_next    = {1'b0, move.target_us};
                active_next = 1'b0;
            end
            else
            begin
                cur_next    = {1'b0, move.origin_us};
                active_next = 1'b1;
            end
        end
        else if (tick && active_reg)
        begin
            if (us_inc < (US_W+1)'(TICKS_PER_MS))
            begin
                us_next = us_inc[US_W-1:0];
            end
            else
            begin
                us_next = '0;
                if (ms_inc >= {1'b0, delay_reg})
                begin
                    ms_next = '0;
                    if (idx_inc < (IDX_W+1)'(RAMP_STEPS))
                    begin
                        idx_next = idx_inc[IDX_W-1:0];
                        cur_next = pos[CUR_W-1:0];
                    end
                    else
                    begin
                        idx_next    = '0;
                        cur_next    = {1'b0, target_reg};
                        active_next = 1'b0;
                    end
                end
                else
                begin
                    ms_next = ms_inc[DLY_W-1:0];
                end
            end
        end
    end

    assign cur_pulse          = cur_reg;
    assign status.pulse_next  = cur_next;
    assign status.moving_next = active_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg    <= PULSE_RESET;
            origin_reg <= '0;
            target_reg <= '0;
            inc_reg    <= '0;
            idx_reg    <= '0;
            delay_reg  <= '0;
            ms_reg     <= '0;
            us_reg     <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            cur_reg    <= cur_next;
            origin_reg <= origin_next;
            target_reg <= target_next;
            inc_reg    <= inc_next;
            idx_reg    <= idx_next;
            delay_reg  <= delay_next;
            ms_reg     <= ms_next;
            us_reg     <= us_next;
            active_reg <= active_next;
        end
    end
endmodule

>>> hdl/servo_pwm_with_linear_ramp_top.sv
// Servo pulse generator with a linear move engine, one channel.
// Input channel: each transaction is either a one-microsecond tick
// (command = 0) or the start of a new move (command = 1) with start and end
// pulse widths and a move time in milliseconds.
// Output channel: exactly one transaction per input transaction, carrying
// the pin level, the commanded pulse width and the moving flag after it.
// Result: registered, valid in the cycle after the input is accepted.
// Throughput: one transaction per cycle while the receiver keeps ready high;
// all work is combinational between input acceptance and the result register.
// Configuration: the user writes period_us through cfg_we/cfg_index/cfg_data
// only while idle (the block does not enforce it); initial_pulse_us writes
// are taken but only reset sets the starting pulse width, always 1500 us.
// Reset: period 20000 us, pulse 1500 us, no move, pin low, output empty.
// Stall: while the receiver holds ready low and a result waits, the input
// ready drops; the result register frees as soon as it is taken.
module servo_pwm_with_linear_ramp_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [spr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spr_pkg::CFG_W-1:0]     cfg_data,
    spr_in_if.sink                        in_ch,
    spr_out_if.source                     out_ch
);
    import spr_pkg::*;

    logic [PERIOD_W-1:0] period_reg;
    logic                out_valid_reg;
    logic                pin_out_reg;
    logic [PULSE_W-1:0]  pulse_out_reg;
    logic                moving_out_reg;

    logic                accept;
    logic                tick;
    logic                start;
    logic                pin_next;
    logic [CUR_W-1:0]    cur_pulse;
    spr_move_t           move;
    spr_ramp_status_t    status;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign tick        = accept && (in_ch.command == CMD_TICK);
    assign start       = accept && (in_ch.command == CMD_MOVE);

    assign move.origin_us    = in_ch.origin_us;
    assign move.target_us    = in_ch.target_us;
    assign move.move_time_ms = in_ch.move_time_ms;

    spr_pwm u_pwm (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .period    (period_reg),
        .cur_pulse (cur_pulse),
        .pin_next  (pin_next)
    );

    spr_ramp u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .start     (start),
        .move      (move),
        .cur_pulse (cur_pulse),
        .status    (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_we && (cfg_index == CFG_PERIOD_US))
        begin
            period_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pin_out_reg    <= pin_next;
            pulse_out_reg  <= status.pulse_next[PULSE_W-1:0];
            moving_out_reg <= status.moving_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.pin_level   = pin_out_reg;
    assign out_ch.pulse_width = pulse_out_reg;
    assign out_ch.moving      = moving_out_reg;
endmodule
